>>> hw/rtl/sct_pkg.sv
// Package for the source character tokenizer: item types, token kind codes,
// scan modes and the result bundle passed from the scanner to the output queue.
// Depends on nothing; used by every module of the block.
package sct_pkg;

  // Width of positions and lengths; both saturate at the all-ones value.
  localparam int PosW = 16;

  // Depth of the result queue in front of the output channel.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    MIdle = 3'd0,
    MWord = 3'd1,
    MNum  = 3'd2,
    MStr  = 3'd3,
    MCmt  = 3'd4,
    MOp   = 3'd5
  } mode_e;

  typedef enum logic [5:0] {
    KId      = 6'd0,
    KStr     = 6'd1,
    KInt     = 6'd2,
    KFor     = 6'd3,
    KWhile   = 6'd4,
    KIf      = 6'd5,
    KElse    = 6'd6,
    KWs      = 6'd7,
    KNl      = 6'd8,
    KCmt     = 6'd9,
    KBang    = 6'd10,
    KNe      = 6'd11,
    KLParen  = 6'd12,
    KRParen  = 6'd13,
    KPercent = 6'd14,
    KAmp     = 6'd15,
    KPipe    = 6'd16,
    KPlus    = 6'd17,
    KMinus   = 6'd18,
    KStar    = 6'd19,
    KSlash   = 6'd20,
    KLBrace  = 6'd21,
    KRBrace  = 6'd22,
    KLBrack  = 6'd23,
    KRBrack  = 6'd24,
    KSemi    = 6'd25,
    KComma   = 6'd26,
    KLt      = 6'd27,
    KLe      = 6'd28,
    KGt      = 6'd29,
    KGe      = 6'd30,
    KAssign  = 6'd31,
    KColonEq = 6'd32,
    KBadStr  = 6'd33,
    KBadCh   = 6'd34
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [PosW-1:0]  start_pos;
    logic [PosW-1:0]  token_len;
    logic             last;
  } out_item_t;

  // Up to two results produced by one accepted item, already compacted:
  // item0 is valid when num >= 1, item1 when num == 2.
  typedef struct packed {
    logic [1:0] num;
    out_item_t  item0;
    out_item_t  item1;
  } lex_res_t;

endpackage

>>> hw/rtl/sct_lex.sv
// Scanner core of the tokenizer: holds the scan state and turns one accepted
// item into at most two results in the same cycle. Depends on sct_pkg.
module sct_lex (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  sct_pkg::in_item_t  item_i,
  input  logic               keep_trivia_i,
  output sct_pkg::lex_res_t  res_o
);

  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChNl     = 8'd10;
  localparam logic [7:0] ChSpace  = 8'd32;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChQuote  = 8'd34;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChLPar   = 8'h28;
  localparam logic [7:0] ChRPar   = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChLt     = 8'h3c;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChGt     = 8'h3e;
  localparam logic [7:0] ChUpA    = 8'd65;
  localparam logic [7:0] ChUpZ    = 8'd90;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChRBrack = 8'h5d;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChLoA    = 8'd97;
  localparam logic [7:0] ChLoZ    = 8'd122;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChPipe   = 8'h7c;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChTilde  = 8'd126;

  localparam int PrefixBytes = 5;
  localparam int PrefixW     = 8 * PrefixBytes;

  // Keyword spellings packed from the low byte up.
  localparam logic [PrefixW-1:0] KwFor   = 40'h00_00_72_6f_66;
  localparam logic [PrefixW-1:0] KwWhile = 40'h65_6c_69_68_77;
  localparam logic [PrefixW-1:0] KwIf    = 40'h00_00_00_66_69;
  localparam logic [PrefixW-1:0] KwElse  = 40'h00_65_73_6c_65;

  localparam int W = sct_pkg::PosW;

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
    sat_inc = (v == {W{1'b1}}) ? v : v + W'(1);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= ChZero && c <= ChNine);
  endfunction

  function automatic logic is_trivia(input sct_pkg::kind_e k);
    is_trivia = (k == sct_pkg::KWs) || (k == sct_pkg::KNl) || (k == sct_pkg::KCmt);
  endfunction

  function automatic sct_pkg::kind_e single_op(input logic [7:0] c);
    case (c)
      ChLPar:   single_op = sct_pkg::KLParen;
      ChRPar:   single_op = sct_pkg::KRParen;
      ChPct:    single_op = sct_pkg::KPercent;
      ChAmp:    single_op = sct_pkg::KAmp;
      ChPipe:   single_op = sct_pkg::KPipe;
      ChPlus:   single_op = sct_pkg::KPlus;
      ChMinus:  single_op = sct_pkg::KMinus;
      ChStar:   single_op = sct_pkg::KStar;
      ChSlash:  single_op = sct_pkg::KSlash;
      ChLBrace: single_op = sct_pkg::KLBrace;
      ChRBrace: single_op = sct_pkg::KRBrace;
      ChLBrack: single_op = sct_pkg::KLBrack;
      ChRBrack: single_op = sct_pkg::KRBrack;
      ChSemi:   single_op = sct_pkg::KSemi;
      ChComma:  single_op = sct_pkg::KComma;
      ChEq:     single_op = sct_pkg::KAssign;
      default:  single_op = sct_pkg::KBadCh;
    endcase
  endfunction

  sct_pkg::mode_e      mode_q, mode_d;
  logic [W-1:0]        idx_q, idx_d;
  logic [W-1:0]        start_q, start_d;
  logic [W-1:0]        len_q, len_d;
  logic [PrefixW-1:0]  prefix_q, prefix_d;
  logic [7:0]          pend_q, pend_d;

  // Slot a: token closed by the pending lexeme. Slot b: token started and
  // finished by the current character on its own.
  logic                a_v, b_v, a_keep, b_keep;
  sct_pkg::kind_e      a_k, b_k, word_k, pend_k, two_k;
  logic [W-1:0]        a_s, a_l, b_s;
  logic                absorbed;
  logic [7:0]          c;
  logic                word_ch;

  assign c       = item_i.ch;
  assign word_ch = is_letter(c) || is_digit(c) || (c == ChUnder);

  always_comb begin
    word_k = sct_pkg::KId;
    if (len_q == W'(3) && prefix_q == KwFor) begin
      word_k = sct_pkg::KFor;
    end else if (len_q == W'(5) && prefix_q == KwWhile) begin
      word_k = sct_pkg::KWhile;
    end else if (len_q == W'(2) && prefix_q == KwIf) begin
      word_k = sct_pkg::KIf;
    end else if (len_q == W'(4) && prefix_q == KwElse) begin
      word_k = sct_pkg::KElse;
    end
  end

  always_comb begin
    case (pend_q)
      ChBang:  begin pend_k = sct_pkg::KBang; two_k = sct_pkg::KNe;      end
      ChLt:    begin pend_k = sct_pkg::KLt;   two_k = sct_pkg::KLe;      end
      ChGt:    begin pend_k = sct_pkg::KGt;   two_k = sct_pkg::KGe;      end
      default: begin pend_k = sct_pkg::KBadCh; two_k = sct_pkg::KColonEq; end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    idx_d    = idx_q;
    start_d  = start_q;
    len_d    = len_q;
    prefix_d = prefix_q;
    pend_d   = pend_q;
    a_v      = 1'b0;
    a_k      = sct_pkg::KId;
    a_s      = start_q;
    a_l      = len_q;
    b_v      = 1'b0;
    b_k      = sct_pkg::KId;
    b_s      = idx_q;
    absorbed = 1'b0;

    if (!item_i.end_of_input) begin
      case (mode_q)
        sct_pkg::MWord: begin
          if (word_ch) begin
            absorbed = 1'b1;
            if (len_q < W'(PrefixBytes)) begin
              for (int i = 0; i < PrefixBytes; i++) begin
                if (len_q[2:0] == 3'(i)) begin
                  prefix_d[8*i +: 8] = prefix_q[8*i +: 8] | c;
                end
              end
            end
            len_d = sat_inc(len_q);
          end
        end
        sct_pkg::MNum: begin
          if (is_digit(c)) begin
            absorbed = 1'b1;
            len_d    = sat_inc(len_q);
          end
        end
        sct_pkg::MStr: begin
          if (c == ChQuote) begin
            absorbed = 1'b1;
            a_v      = 1'b1;
            a_k      = sct_pkg::KStr;
            a_l      = sat_inc(len_q);
            mode_d   = sct_pkg::MIdle;
            len_d    = '0;
          end else if (c == ChTab || (c >= ChSpace && c <= ChTilde)) begin
            absorbed = 1'b1;
            len_d    = sat_inc(len_q);
          end
        end
        sct_pkg::MCmt: begin
          if (c != ChNl) begin
            absorbed = 1'b1;
            len_d    = sat_inc(len_q);
          end
        end
        sct_pkg::MOp: begin
          if (c == ChEq) begin
            absorbed = 1'b1;
            a_v      = 1'b1;
            a_k      = two_k;
            a_l      = W'(2);
            mode_d   = sct_pkg::MIdle;
            len_d    = '0;
            pend_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end

    // Flush of the pending lexeme, on the end marker or on a character
    // that does not continue it.
    if (item_i.end_of_input || !absorbed) begin
      a_v = 1'b1;
      a_l = len_q;
      case (mode_q)
        sct_pkg::MWord: a_k = word_k;
        sct_pkg::MNum:  a_k = sct_pkg::KInt;
        sct_pkg::MStr:  a_k = sct_pkg::KBadStr;
        sct_pkg::MCmt:  a_k = sct_pkg::KCmt;
        sct_pkg::MOp:   begin a_k = pend_k; a_l = W'(1); end
        default:        a_v = 1'b0;
      endcase
      mode_d   = sct_pkg::MIdle;
      len_d    = '0;
      prefix_d = '0;
      pend_d   = '0;
    end

    if (item_i.end_of_input) begin
      idx_d   = '0;
      start_d = '0;
    end else begin
      idx_d = sat_inc(idx_q);
      if (!absorbed) begin
        if (is_letter(c) || c == ChUnder) begin
          mode_d   = sct_pkg::MWord;
          start_d  = idx_q;
          len_d    = W'(1);
          prefix_d = {{(PrefixW-8){1'b0}}, c};
        end else if (is_digit(c)) begin
          mode_d  = sct_pkg::MNum;
          start_d = idx_q;
          len_d   = W'(1);
        end else if (c == ChQuote) begin
          mode_d  = sct_pkg::MStr;
          start_d = idx_q;
          len_d   = W'(1);
        end else if (c == ChNl) begin
          b_v = 1'b1;
          b_k = sct_pkg::KNl;
        end else if (c == ChSpace) begin
          b_v = 1'b1;
          b_k = sct_pkg::KWs;
        end else if (c == ChHash) begin
          mode_d  = sct_pkg::MCmt;
          start_d = idx_q;
          len_d   = W'(1);
        end else if (c == ChBang || c == ChLt || c == ChGt || c == ChColon) begin
          mode_d  = sct_pkg::MOp;
          start_d = idx_q;
          len_d   = W'(1);
          pend_d  = c;
        end else begin
          b_v = 1'b1;
          b_k = single_op(c);
        end
      end
    end
  end

  // Drop suppressed trivia, then pack the surviving results to the front.
  always_comb begin
    a_keep = a_v && (keep_trivia_i || !is_trivia(a_k));
    b_keep = b_v && (keep_trivia_i || !is_trivia(b_k));
    res_o  = '0;
    if (a_keep) begin
      res_o.item0 = '{kind: a_k, start_pos: a_s, token_len: a_l, last: !b_keep};
      res_o.item1 = '{kind: b_k, start_pos: b_s, token_len: W'(1), last: 1'b1};
      res_o.num   = b_keep ? 2'd2 : 2'd1;
    end else if (b_keep) begin
      res_o.item0 = '{kind: b_k, start_pos: b_s, token_len: W'(1), last: 1'b1};
      res_o.num   = 2'd1;
    end
    if (!fire_i) begin
      res_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sct_pkg::MIdle;
      idx_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      prefix_q <= '0;
      pend_q   <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      idx_q    <= idx_d;
      start_q  <= start_d;
      len_q    <= len_d;
      prefix_q <= prefix_d;
      pend_q   <= pend_d;
    end
  end

  a_pair_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num == 2'd2) |-> (!res_o.item0.last && res_o.item1.last))
    else $error("two results must carry last on the second only");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == sct_pkg::MIdle) |-> (len_q == '0 && prefix_q == '0))
    else $error("idle scanner holds a partial lexeme");

  a_eoi_rewind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.end_of_input) |=> (idx_q == '0 && mode_q == sct_pkg::MIdle))
    else $error("end marker did not rewind the scanner");

endmodule

>>> hw/rtl/sct_ofifo.sv
// Result queue of the tokenizer: takes up to two results per cycle while not full
// and hands one per cycle to the output channel unless stalled. Depends on sct_pkg.
module sct_ofifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sct_pkg::lex_res_t   push_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sct_pkg::out_item_t  out_data_o
);

  localparam int D  = sct_pkg::FifoDepth;
  localparam int PW = sct_pkg::FifoPtrW;
  localparam int CW = sct_pkg::FifoCntW;

  sct_pkg::out_item_t mem_q [D];
  logic [PW-1:0]      head_q, head_d, tail_q, tail_d, tail_nx;
  logic [CW-1:0]      count_q, count_d;
  logic               pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Room for two results is needed before an item may be taken.
  assign full_o      = (count_q > CW'(D - 2));
  assign tail_nx     = tail_q + PW'(1);

  always_comb begin
    head_d  = pop ? head_q + PW'(1) : head_q;
    tail_d  = tail_q + PW'(push_i.num);
    count_d = count_q + CW'(push_i.num) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[tail_q] <= push_i.item0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[tail_nx] <= push_i.item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(D))
    else $error("result queue overflow");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (push_i.num == 2'd0))
    else $error("results pushed while the queue lacks room");

  a_push_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && push_i.num != 2'd0) |=> out_valid_o)
    else $error("pushed result not presented");

endmodule

>>> hw/rtl/source_char_tokenizer.sv
// Top level of the source character tokenizer: configuration register,
// scanner core and result queue. Depends on sct_pkg, sct_lex and sct_ofifo.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i   (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i              | cfg_wdata_i (keep_trivia)
//
// An item is scanned in the cycle it is accepted; its results, at most two,
// are registered in the result queue and leave one per cycle unless the output stalls.
// One item per cycle is sustained while items produce at most one result and
// the output does not stall; the two results of one item leave one after the
// other through the single output port of the four-entry result queue.
// Reset clears the scan state, the character index, the queue and keep_trivia.
// in_stall_o rises when the queue has room for fewer than two results.
module source_char_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sct_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sct_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  logic               keep_trivia_q;
  logic               in_fire;
  logic               full;
  sct_pkg::lex_res_t  lex_res;

  // Users must write the configuration register only while idle; no logic enforces it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_trivia_q <= 1'b0;
    end else if (cfg_we_i) begin
      keep_trivia_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !in_stall_o;

  // The scanner updates its state on each accepted item and hands the
  // resulting tokens, trivia already filtered, to the queue.
  sct_lex u_lex (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .item_i        (in_data_i),
    .keep_trivia_i (keep_trivia_q),
    .res_o         (lex_res)
  );

  // The queue decouples the two sides so that input keeps flowing while a
  // finished token waits on a stalled output.
  sct_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (lex_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
